// ===== design/cdfpts_pkg.sv =====
package cdfpts_pkg;

  localparam int ENTRIES_DEF = 4096;
  localparam int FRAC_DEF = 16;
  localparam int CFG_W = 13;
  localparam int IDX_W = 12;
  localparam int COORD_W = 32;
  localparam int WGT_W = 17;
  localparam int RND_W = 16;

  localparam logic [1:0] CMD_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_LOAD_CORNER = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    OP_LOAD_WEIGHT,
    OP_LOAD_CORNER,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [IDX_W-1:0]    entry_index;
    logic [1:0]          corner;
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [COORD_W-1:0]  coord_z;
    logic [WGT_W-1:0]    cum_weight;
    logic [RND_W-1:0]    pick_random;
    logic [RND_W-1:0]    rand_s;
    logic [RND_W-1:0]    rand_t;
    logic [RND_W-1:0]    rand_u;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SEARCH,
    ST_CORNER,
    ST_DRAIN,
    ST_OUT
  } st_t;

endpackage

// ===== design/cdfpts_if.sv =====
interface cdfpts_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           cmd;
  logic [cdfpts_pkg::IDX_W-1:0]         entry_index;
  logic [1:0]                           corner;
  logic signed [cdfpts_pkg::COORD_W-1:0] coord_x;
  logic signed [cdfpts_pkg::COORD_W-1:0] coord_y;
  logic signed [cdfpts_pkg::COORD_W-1:0] coord_z;
  logic [cdfpts_pkg::WGT_W-1:0]         cum_weight;
  logic [cdfpts_pkg::RND_W-1:0]         pick_random;
  logic [cdfpts_pkg::RND_W-1:0]         rand_s;
  logic [cdfpts_pkg::RND_W-1:0]         rand_t;
  logic [cdfpts_pkg::RND_W-1:0]         rand_u;

  modport source (output valid, cmd, entry_index, corner, coord_x, coord_y, coord_z,
                  cum_weight, pick_random, rand_s, rand_t, rand_u, input ready);
  modport sink (input valid, cmd, entry_index, corner, coord_x, coord_y, coord_z,
                cum_weight, pick_random, rand_s, rand_t, rand_u, output ready);
endinterface

interface cdfpts_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cdfpts_pkg::COORD_W-1:0] pos_x;
  logic signed [cdfpts_pkg::COORD_W-1:0] pos_y;
  logic signed [cdfpts_pkg::COORD_W-1:0] pos_z;
  logic [cdfpts_pkg::IDX_W-1:0]          chosen_entry;

  modport source (output valid, pos_x, pos_y, pos_z, chosen_entry, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, chosen_entry, output ready);
endinterface

// ===== design/cdfpts_ram.sv =====
module cdfpts_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cdfpts_front.sv =====
module cdfpts_front #(
  parameter int ENTRIES = cdfpts_pkg::ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  cdfpts_req_if.sink        req,
  output logic              q_valid,
  input  logic              q_ready,
  output cdfpts_pkg::item_t q_item
);

  localparam int DEPTH = 4;

  cdfpts_pkg::item_t fifo [DEPTH];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] fill;
  logic       keep;
  logic       push;
  logic       pop;
  cdfpts_pkg::op_t op;
  logic       in_range;

  assign in_range = {20'd0, req.entry_index} < 32'(ENTRIES);

  always_comb begin
    op = cdfpts_pkg::OP_SAMPLE;
    keep = 1'b0;
    unique case (req.cmd)
      cdfpts_pkg::CMD_LOAD_WEIGHT: begin
        op = cdfpts_pkg::OP_LOAD_WEIGHT;
        keep = in_range;
      end
      cdfpts_pkg::CMD_LOAD_CORNER: begin
        op = cdfpts_pkg::OP_LOAD_CORNER;
        keep = in_range;
      end
      cdfpts_pkg::CMD_SAMPLE: begin
        op = cdfpts_pkg::OP_SAMPLE;
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready = fill != 3'(DEPTH);
  assign push = req.valid && req.ready && keep;
  assign q_valid = fill != 3'd0;
  assign pop = q_valid && q_ready;
  assign q_item = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= '{op: op, entry_index: req.entry_index, corner: req.corner,
                      coord_x: req.coord_x, coord_y: req.coord_y, coord_z: req.coord_z,
                      cum_weight: req.cum_weight, pick_random: req.pick_random,
                      rand_s: req.rand_s, rand_t: req.rand_t, rand_u: req.rand_u};
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 2'd1;
      if (pop) rptr <= rptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
    end
  end

endmodule

// ===== design/cdfpts_back.sv =====
module cdfpts_back #(
  parameter int ENTRIES = cdfpts_pkg::ENTRIES_DEF,
  parameter int FRACTION_BITS = cdfpts_pkg::FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [$clog2(ENTRIES+1)-1:0] n,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  cdfpts_pkg::item_t            q_item,
  cdfpts_rsp_if.source                 rsp
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int SW = FRACTION_BITS + 3;
  localparam int PW = SW + 32;
  localparam int AW = SW + 34;
  localparam int LSH = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int RSH = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam logic signed [SW-1:0] ONE = SW'(64'd1 << FRACTION_BITS);

  cdfpts_pkg::st_t st, st_next;
  cdfpts_pkg::item_t cur;

  logic [CW-1:0] lo, count, half, probe, lo_s, count_s;
  logic          lt;
  logic [IW-1:0] sel;
  logic [1:0]    ci;
  logic          rd_v, pv;
  logic [1:0]    rd_c;
  logic signed [SW-1:0] w [4];
  logic signed [SW-1:0] fw [4];
  logic signed [PW-1:0] px, py, pz;
  logic signed [AW-1:0] ax, ay, az;
  logic signed [AW-1:0] sx, sy, sz;

  logic          w_we;
  logic [IW-1:0] w_waddr, w_raddr;
  logic [cdfpts_pkg::WGT_W-1:0] w_rdata;
  logic          c_we;
  logic [IW+1:0] c_waddr, c_raddr;
  logic [3*cdfpts_pkg::COORD_W-1:0] c_rdata;

  logic o_valid;
  logic signed [31:0] o_x, o_y, o_z;
  logic [cdfpts_pkg::IDX_W-1:0] o_e;
  logic o_load;

  cdfpts_ram #(.W(cdfpts_pkg::WGT_W), .D(ENTRIES)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(cur.cum_weight),
    .raddr(w_raddr), .rdata(w_rdata)
  );

  cdfpts_ram #(.W(3 * cdfpts_pkg::COORD_W), .D(4 * ENTRIES)) u_corner (
    .clk(clk), .we(c_we), .waddr(c_waddr),
    .wdata({cur.coord_x, cur.coord_y, cur.coord_z}),
    .raddr(c_raddr), .rdata(c_rdata)
  );

  // one lower-bound step on the probe read last cycle
  always_comb begin
    half = count >> 1;
    probe = lo + half;
    lt = w_rdata < {1'b0, cur.pick_random};
    lo_s = lt ? probe + CW'(1) : lo;
    count_s = lt ? count - half - CW'(1) : half;
  end

  // cube folding into barycentric weights
  always_comb begin
    logic signed [SW-1:0] s, t, u, k;
    k = '0;
    s = SW'(cur.rand_s >> RSH) << LSH;
    t = SW'(cur.rand_t >> RSH) << LSH;
    u = SW'(cur.rand_u >> RSH) << LSH;
    if (s + t > ONE) begin
      s = ONE - s;
      t = ONE - t;
    end
    if (t + u > ONE) begin
      k = u;
      u = ONE - s - t;
      t = ONE - k;
    end else if (s + t + u > ONE) begin
      k = u;
      u = s + t + u - ONE;
      s = ONE - t - k;
    end
    fw[0] = ONE - s - t - u;
    fw[1] = s;
    fw[2] = t;
    fw[3] = u;
  end

  always_comb begin
    st_next = st;
    unique case (st)
      cdfpts_pkg::ST_IDLE: if (q_valid) st_next = cdfpts_pkg::ST_EXEC;
      cdfpts_pkg::ST_EXEC: begin
        st_next = (cur.op == cdfpts_pkg::OP_SAMPLE) ? cdfpts_pkg::ST_SEARCH
                                                    : cdfpts_pkg::ST_IDLE;
      end
      cdfpts_pkg::ST_SEARCH: if (count_s == '0) st_next = cdfpts_pkg::ST_CORNER;
      cdfpts_pkg::ST_CORNER: if (ci == 2'd3) st_next = cdfpts_pkg::ST_DRAIN;
      cdfpts_pkg::ST_DRAIN: if (!rd_v && !pv) st_next = cdfpts_pkg::ST_OUT;
      cdfpts_pkg::ST_OUT: if (!o_valid || rsp.ready) st_next = cdfpts_pkg::ST_IDLE;
      default: st_next = cdfpts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready = st == cdfpts_pkg::ST_IDLE;
    w_we = (st == cdfpts_pkg::ST_EXEC) && (cur.op == cdfpts_pkg::OP_LOAD_WEIGHT);
    c_we = (st == cdfpts_pkg::ST_EXEC) && (cur.op == cdfpts_pkg::OP_LOAD_CORNER);
    w_waddr = IW'(cur.entry_index);
    c_waddr = {IW'(cur.entry_index), cur.corner};
    w_raddr = (st == cdfpts_pkg::ST_SEARCH) ? IW'(lo_s + (count_s >> 1)) : IW'(n >> 1);
    c_raddr = {sel, ci};
    o_load = (st == cdfpts_pkg::ST_OUT) && (!o_valid || rsp.ready);
  end

  assign sx = ax >>> FRACTION_BITS;
  assign sy = ay >>> FRACTION_BITS;
  assign sz = az >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (st == cdfpts_pkg::ST_IDLE && q_valid) cur <= q_item;
    if (st == cdfpts_pkg::ST_EXEC) begin
      lo <= '0;
      count <= n;
      w <= fw;
      ax <= '0;
      ay <= '0;
      az <= '0;
    end
    if (st == cdfpts_pkg::ST_SEARCH) begin
      lo <= lo_s;
      count <= count_s;
      if (count_s == '0) sel <= IW'((lo_s >= n) ? n - CW'(1) : lo_s);
    end
    rd_c <= ci;
    px <= w[rd_c] * $signed(c_rdata[95:64]);
    py <= w[rd_c] * $signed(c_rdata[63:32]);
    pz <= w[rd_c] * $signed(c_rdata[31:0]);
    if (pv) begin
      ax <= ax + AW'(px);
      ay <= ay + AW'(py);
      az <= az + AW'(pz);
    end
    if (o_load) begin
      o_x <= sx[31:0];
      o_y <= sy[31:0];
      o_z <= sz[31:0];
      o_e <= cdfpts_pkg::IDX_W'(sel);
    end
    if (rst) begin
      st <= cdfpts_pkg::ST_IDLE;
      ci <= '0;
      rd_v <= 1'b0;
      pv <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      st <= st_next;
      ci <= (st == cdfpts_pkg::ST_CORNER) ? ci + 2'd1 : 2'd0;
      rd_v <= st == cdfpts_pkg::ST_CORNER;
      pv <= rd_v;
      if (o_load) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.pos_x = o_x;
  assign rsp.pos_y = o_y;
  assign rsp.pos_z = o_z;
  assign rsp.chosen_entry = o_e;

endmodule

// ===== design/cdf_pick_tetrahedron_point_sampler.sv =====
// Samples a point in one tetrahedron of a loaded table. Incoming beats go into a four-deep
// queue; a load is then written to its memory in the back end's EXEC state. A sample makes
// one lower-bound step per cycle over the n entries in use on the weight memory read port,
// then four reads of the corner memory port, then a short multiply-accumulate drain and the
// move to the output register, which frees the back end while the result beat waits.
module cdf_pick_tetrahedron_point_sampler #(
  parameter int ENTRIES = cdfpts_pkg::ENTRIES_DEF,
  parameter int FRACTION_BITS = cdfpts_pkg::FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cdfpts_pkg::CFG_W-1:0] cfg_wdata,
  cdfpts_req_if.sink                   req,
  cdfpts_rsp_if.source                 rsp
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic [cdfpts_pkg::CFG_W-1:0] entries_in_use;
  logic [CW-1:0]                n;
  logic                         q_valid;
  logic                         q_ready;
  cdfpts_pkg::item_t            q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= cdfpts_pkg::CFG_W'(1);
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_comb begin
    if (entries_in_use == '0) n = CW'(1);
    else if ({19'd0, entries_in_use} > 32'(ENTRIES)) n = CW'(ENTRIES);
    else n = CW'(entries_in_use);
  end

  cdfpts_front #(.ENTRIES(ENTRIES)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  cdfpts_back #(.ENTRIES(ENTRIES), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk(clk), .rst(rst), .n(n),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .rsp(rsp)
  );

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |=> !q_ready)
    else $error("back end took a second beat while busy");

  a_n_range: assert property (@(posedge clk) disable iff (rst)
    (n != '0) && ({{(32-CW){1'b0}}, n} <= 32'(ENTRIES)))
    else $error("search length out of range");

endmodule
